[src/fpfa_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpfa_pkg
// Shared types and constants of the fixed point / float unit.
// ----------------------------------------------------------------------------
package fpfa_pkg;

    localparam int unsigned MAX_WL    = 32;
    localparam int unsigned DIV_BITS  = 64;
    localparam int unsigned DIV_STEP  = 4;
    localparam int unsigned DIV_STGS  = DIV_BITS / DIV_STEP;

    localparam logic [1:0] OP_F2X = 2'd0;
    localparam logic [1:0] OP_X2F = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    localparam logic [2:0] ADDR_WL = 3'd0;
    localparam logic [2:0] ADDR_IL = 3'd4;

    localparam logic [5:0] WL_RESET = 6'd16;
    localparam logic [4:0] IL_RESET = 5'd7;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] operand_a;
        logic [31:0] operand_b;
    } t_in;

    typedef struct packed {
        logic [31:0] result;
        logic        divide_by_zero;
    } t_out;

endpackage

[src/fixed_point_float_alu.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_point_float_alu
// Pipelined fixed point unit: float/fixed conversion, multiply and divide.
// ----------------------------------------------------------------------------
// One request is taken per cycle unless the output stalls. The depth is
// set by the divider: a 64-bit restoring divide that resolves four quotient
// bits in each of 16 stages, behind three stages of operand preparation
// and one of result sign-fixup. Conversion and multiply requests travel
// the same pipe, so results leave in request order. A stall on the output
// freezes the whole pipe.
module fixed_point_float_alu (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  fpfa_pkg::t_in     i_req,
    output logic              o_valid,
    input  logic              i_stall,
    output fpfa_pkg::t_out    o_res,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int unsigned DEPTH = 4 + fpfa_pkg::DIV_STGS;
    localparam int unsigned LAST  = DEPTH - 1;

    typedef struct packed {
        logic [1:0]  op;
        logic [5:0]  wl;
        logic [4:0]  fl;
        logic        na;
        logic        nb;
        logic        dz;
        logic [31:0] ma;
        logic [31:0] mb;
        logic [31:0] rem;
        logic [63:0] dq;
        logic [63:0] aux;
        logic [5:0]  pos;
        logic [31:0] res;
    } t_st;

    logic [5:0] r_word_length;
    logic [4:0] r_int_length;
    t_st        r_st [DEPTH];
    t_st        n_st [DEPTH];
    logic       r_vld [DEPTH];
    logic       en;

    function automatic logic [31:0] f_mask(input logic [5:0] wl);
        f_mask = 32'hFFFF_FFFF >> (6'd32 - wl);
    endfunction

    function automatic logic [31:0] f_sign(input logic [31:0] mag, input logic neg,
                                           input logic [5:0] wl);
        f_sign = (neg ? (32'd0 - mag) : mag) & f_mask(wl);
    endfunction

    assign pready = 1'b1;
    assign prdata = (paddr == fpfa_pkg::ADDR_IL) ? {27'd0, r_int_length}
                                                : {26'd0, r_word_length};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_length <= fpfa_pkg::WL_RESET;
            r_int_length  <= fpfa_pkg::IL_RESET;
        end else if (psel && penable && pwrite) begin
            if (paddr == fpfa_pkg::ADDR_WL) begin
                r_word_length <= pwdata[5:0];
            end else if (paddr == fpfa_pkg::ADDR_IL) begin
                r_int_length <= pwdata[4:0];
            end
        end
    end

    assign en      = !(r_vld[LAST] && i_stall);
    assign o_stall = !en;
    assign o_valid = r_vld[LAST];
    assign o_res.result         = r_st[LAST].res;
    assign o_res.divide_by_zero = r_st[LAST].dz;

    always_comb begin
        t_st         s;
        logic [5:0]  wl;
        logic [31:0] msk;
        logic [31:0] xa;
        logic [31:0] xb;
        logic [7:0]  e;
        logic [9:0]  sh;
        logic [23:0] sig;
        logic [63:0] v;
        logic [5:0]  p;
        logic [3:0]  rs;
        logic [31:0] rmsk;
        logic [31:0] rem;
        logic [31:0] half;
        logic [24:0] q;
        logic [63:0] pr;
        logic [32:0] rsh;
        logic [7:0]  expo;

        // stage 0: operands and clamped format
        s = '0;
        s.op = i_req.opcode;
        wl = r_word_length;
        if (wl < 6'd2) wl = 6'd2;
        if (wl > 6'(fpfa_pkg::MAX_WL)) wl = 6'(fpfa_pkg::MAX_WL);
        s.wl = wl;
        if (6'(r_int_length) > wl - 6'd1) s.fl = 5'd0;
        else s.fl = 5'(wl - 6'd1 - 6'(r_int_length));
        s.ma = i_req.operand_a;
        s.mb = i_req.operand_b;
        n_st[0] = s;

        // stage 1: sign and magnitude of the fixed operands
        s   = r_st[0];
        msk = f_mask(s.wl);
        xa  = s.ma & msk;
        xb  = s.mb & msk;
        if (s.op == fpfa_pkg::OP_F2X) begin
            s.na = s.ma[31];
        end else begin
            s.na = xa[5'(s.wl - 6'd1)];
            s.ma = s.na ? ((~xa + 32'd1) & msk) : xa;
        end
        s.nb = xb[5'(s.wl - 6'd1)];
        s.mb = s.nb ? ((~xb + 32'd1) & msk) : xb;
        n_st[1] = s;

        // stage 2: shift, product, leading one, divider load
        s   = r_st[1];
        e   = s.ma[30:23];
        sig = {1'b1, s.ma[22:0]};
        sh  = 10'(e) + 10'(s.fl) - 10'd150;
        v   = '0;
        if (e != 8'd0) begin
            if (!sh[9]) begin
                if (sh < 10'd40) v = 64'(sig) << sh[5:0];
            end else if ((10'd0 - sh) < 10'd24) begin
                v = 64'(sig >> 5'(10'd0 - sh));
            end
        end
        p = '0;
        for (int i = 0; i < 32; i++) begin
            if (s.ma[i]) p = 6'(i);
        end
        s.pos = p;
        if (s.op == fpfa_pkg::OP_F2X) s.aux = v;
        else s.aux = 64'(s.ma) * 64'(s.mb);
        s.rem = '0;
        s.dq  = 64'(s.ma) << s.fl;
        s.dz  = (s.op == fpfa_pkg::OP_DIV) && (s.mb == 32'd0);
        n_st[2] = s;

        for (int k = 3; k < LAST; k++) begin
            s = r_st[k-1];
            // four restoring divide steps
            for (int j = 0; j < fpfa_pkg::DIV_STEP; j++) begin
                rsh  = {s.rem, s.dq[63]};
                s.dq = {s.dq[62:0], 1'b0};
                if (rsh >= 33'(s.mb)) begin
                    rsh     = rsh - 33'(s.mb);
                    s.dq[0] = 1'b1;
                end
                s.rem = rsh[31:0];
            end
            if (k == 3) begin
                case (s.op)
                    fpfa_pkg::OP_F2X: s.res = f_sign(s.aux[31:0], s.na, s.wl);
                    fpfa_pkg::OP_X2F: begin
                        p = s.pos;
                        if (p <= 6'd23) begin
                            q = 25'(s.ma << 5'(6'd23 - p));
                        end else begin
                            rs   = 4'(p - 6'd23);
                            rmsk = (32'd1 << rs) - 32'd1;
                            rem  = s.ma & rmsk;
                            half = 32'd1 << (rs - 4'd1);
                            q    = 25'(s.ma >> rs);
                            if (rem > half || (rem == half && q[0])) q = q + 25'd1;
                            if (q[24]) begin
                                q = q >> 1;
                                p = p + 6'd1;
                            end
                        end
                        s.pos = p;
                        s.aux = 64'(q);
                    end
                    fpfa_pkg::OP_MUL: begin
                        pr = s.aux;
                        if (s.na != s.nb) pr = pr + ((64'd1 << s.fl) - 64'd1);
                        s.aux = pr >> s.fl;
                    end
                    default: ;
                endcase
            end
            if (k == 4) begin
                case (s.op)
                    fpfa_pkg::OP_X2F: begin
                        expo  = 8'(s.pos) + 8'd127 - 8'(s.fl);
                        if (s.ma == 32'd0) s.res = '0;
                        else s.res = {s.na, expo, s.aux[22:0]};
                    end
                    fpfa_pkg::OP_MUL: s.res = f_sign(s.aux[31:0], s.na != s.nb, s.wl);
                    default: ;
                endcase
            end
            n_st[k] = s;
        end

        // last stage: quotient sign
        s = r_st[LAST-1];
        if (s.op == fpfa_pkg::OP_DIV) begin
            s.res = s.dz ? 32'd0 : f_sign(s.dq[31:0], s.na != s.nb, s.wl);
        end
        n_st[LAST] = s;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DEPTH; k++) r_vld[k] <= 1'b0;
        end else if (en) begin
            r_vld[0] <= i_valid;
            for (int k = 1; k < DEPTH; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < DEPTH; k++) r_st[k] <= n_st[k];
        end
    end

`ifndef NO_ASSERTIONS
    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_res.divide_by_zero |-> o_res.result == 32'd0)
        else $error("divide by zero with nonzero result");

    a_dz_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_res.divide_by_zero |-> r_st[LAST].op == fpfa_pkg::OP_DIV)
        else $error("divide by zero flag on non-divide request");

    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_vld[LAST]) && $stable(o_res))
        else $error("output changed while stalled");

    a_wl_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[0] |-> r_st[0].wl >= 6'd2 && r_st[0].wl <= 6'(fpfa_pkg::MAX_WL))
        else $error("word length clamp failed");
`endif

endmodule
